FILE: design/mjd_pkg.sv
// ----------------------------------------------------------------------------
// mjd_pkg
// Types and constants shared by the job dispatcher modules.
// ----------------------------------------------------------------------------
package mjd_pkg;

   localparam int TIME_W  = 32;
   localparam int BUSY_W  = 48;
   localparam int JOB_W   = 16;
   localparam int CNT_W   = 32;
   localparam int QLEN_W  = 5;
   localparam int SIDX_IN_W = 3;
   localparam int CFG_SRV_W = 4;
   localparam int CFG_QL_W  = 5;

   localparam logic [BUSY_W-1:0] BUSY_MAX = {BUSY_W{1'b1}};
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

   // register indexes on the configuration port
   localparam logic REG_SERVERS = 1'b0;
   localparam logic REG_QLIMIT  = 1'b1;

   // event kinds
   localparam logic ACT_ARRIVAL   = 1'b0;
   localparam logic ACT_DEPARTURE = 1'b1;

   typedef enum logic [2:0] {
      ST_STARTED     = 3'd0,
      ST_QUEUED      = 3'd1,
      ST_DROPPED     = 3'd2,
      ST_COMPLETED   = 3'd3,
      ST_Q_STARTED   = 3'd4,
      ST_BAD_DEPART  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SEND1,
      FSM_SEND2
   } fsm_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sel_second;
   } cmd_type;

   typedef struct packed {
      logic two_results;
   } stat_type;

   typedef struct packed {
      status_type          status;
      logic                last;
      logic [JOB_W-1:0]    job_number;
      logic [2:0]          server_used;
      logic [TIME_W-1:0]   finish_at;
      logic [TIME_W-1:0]   waited;
      logic [TIME_W-1:0]   in_system;
      logic [QLEN_W-1:0]   queue_length;
      logic [BUSY_W-1:0]   busy_time_total;
      logic [CNT_W-1:0]    arrivals_seen;
      logic [CNT_W-1:0]    jobs_dropped;
      logic [CNT_W-1:0]    jobs_done;
   } rsp_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [TIME_W-1:0] sub_floor(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
      sub_floor = (a > b) ? a - b : '0;
   endfunction

   function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      add_sat = s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

FILE: design/mjd_ram.sv
// ----------------------------------------------------------------------------
// mjd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mjd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/mjd_ctrl.sv
// ----------------------------------------------------------------------------
// mjd_ctrl
// Event sequencer: accept, execute, then hand out one or two results.
// ----------------------------------------------------------------------------
module mjd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output mjd_pkg::cmd_type  cmd,
   input  mjd_pkg::stat_type stat
);
   import mjd_pkg::*;

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (req_tvalid) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            state_in = FSM_SEND1;
         end
         FSM_SEND1: begin
            if (rsp_tready) state_in = stat.two_results ? FSM_SEND2 : FSM_IDLE;
         end
         FSM_SEND2: begin
            if (rsp_tready) state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      rsp_tvalid     = 1'b0;
      cmd.capture    = 1'b0;
      cmd.exec       = 1'b0;
      cmd.sel_second = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         FSM_EXEC: begin
            cmd.exec = 1'b1;
         end
         FSM_SEND1: begin
            rsp_tvalid = 1'b1;
         end
         FSM_SEND2: begin
            rsp_tvalid     = 1'b1;
            cmd.sel_second = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end
endmodule

FILE: design/mjd_datapath.sv
// ----------------------------------------------------------------------------
// mjd_datapath
// Server table, wait queue, busy-time accumulator, counters and results.
// ----------------------------------------------------------------------------
module mjd_datapath #(
   parameter int MAX_SERVERS = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mjd_pkg::cmd_type                  cmd,
   output mjd_pkg::stat_type                 stat,
   input  logic [mjd_pkg::CFG_SRV_W-1:0]     servers_in_use,
   input  logic [mjd_pkg::CFG_QL_W-1:0]      queue_limit,
   input  logic                              action,
   input  logic [mjd_pkg::TIME_W-1:0]        event_time,
   input  logic [mjd_pkg::TIME_W-1:0]        service_length,
   input  logic [mjd_pkg::SIDX_IN_W-1:0]     server_index,
   input  logic [mjd_pkg::JOB_W-1:0]         finishing_job,
   output mjd_pkg::rsp_type                  result
);
   import mjd_pkg::*;

   localparam int SIDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int POP_W  = $clog2(MAX_SERVERS + 1);
   localparam int QENT_W = JOB_W + 2 * TIME_W;

   // captured event
   logic                  act_ff;
   logic [TIME_W-1:0]     now_ff, svc_ff;
   logic [SIDX_IN_W-1:0]  sidx_ff;
   logic [JOB_W-1:0]      fjob_ff;

   // server table
   logic                  busy_ff   [MAX_SERVERS];
   logic                  busy_in   [MAX_SERVERS];
   logic [JOB_W-1:0]      sjob_ff   [MAX_SERVERS];
   logic [TIME_W-1:0]     sarr_ff   [MAX_SERVERS];
   logic [TIME_W-1:0]     sstart_ff [MAX_SERVERS];

   logic                  swr_en;
   logic [SIDX_W-1:0]     swr_idx;
   logic [JOB_W-1:0]      swr_job;
   logic [TIME_W-1:0]     swr_arr;

   logic [QIDX_W-1:0]     head_ff, head_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic [JOB_W-1:0]      next_job_ff, next_job_in;
   logic [TIME_W-1:0]     last_ff, last_in;
   logic [BUSY_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]      arrivals_ff, arrivals_in;
   logic [CNT_W-1:0]      drops_ff, drops_in;
   logic [CNT_W-1:0]      done_ff, done_in;

   rsp_type               r1_ff, r1_in, r2_ff, r2_in;
   logic                  two_ff, two_in;

   // wait queue storage
   logic                  q_we;
   logic [QIDX_W-1:0]     q_waddr;
   logic [QENT_W-1:0]     q_wdata, q_rdata;

   mjd_ram #(.WIDTH(QENT_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (head_ff),
      .rd_data (q_rdata)
   );

   logic [POP_W-1:0]          pop;
   logic [TIME_W-1:0]         elapsed;
   logic [TIME_W+POP_W-1:0]   prod;
   logic [BUSY_W:0]           acc_sum;
   logic [BUSY_W-1:0]         acc_new;
   logic                      found;
   logic [SIDX_W-1:0]         free_idx;
   logic [SIDX_W-1:0]         sidx;
   logic [31:0]               sidx_wide, free_wide, tail_wide, qlim, cnt_wide, cnt_dec_wide;
   logic                      sidx_ok, depart_ok, start_next;
   logic [QIDX_W-1:0]         tail, head_next;
   logic [JOB_W-1:0]          h_job;
   logic [TIME_W-1:0]         h_arr, h_svc;

   assign {h_svc, h_arr, h_job} = q_rdata;

   always_comb begin
      pop = '0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
         pop = pop + POP_W'(busy_ff[i]);
      end
      elapsed = (now_ff > last_ff) ? now_ff - last_ff : '0;
      prod    = elapsed * pop;
      acc_sum = {1'b0, acc_ff} + (BUSY_W + 1)'(prod);
      acc_new = acc_sum[BUSY_W] ? BUSY_MAX : acc_sum[BUSY_W-1:0];

      // lowest free server among those enabled
      found    = 1'b0;
      free_idx = '0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
         if (!found && (32'(i) < 32'(servers_in_use)) && !busy_ff[i]) begin
            found    = 1'b1;
            free_idx = SIDX_W'(i);
         end
      end
      free_wide = 32'(free_idx);

      sidx_wide = 32'(sidx_ff);
      sidx      = sidx_wide[SIDX_W-1:0];
      sidx_ok   = sidx_wide < 32'(MAX_SERVERS);
      depart_ok = sidx_ok && busy_ff[sidx] && (sjob_ff[sidx] == fjob_ff);
      start_next = (count_ff != '0) && (sidx_wide < 32'(servers_in_use));

      qlim = (32'(queue_limit) > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH) : 32'(queue_limit);

      tail_wide = 32'(head_ff) + 32'(count_ff);
      if (tail_wide >= 32'(QUEUE_DEPTH)) tail_wide = tail_wide - 32'(QUEUE_DEPTH);
      tail      = tail_wide[QIDX_W-1:0];
      head_next = (32'(head_ff) + 32'd1 == 32'(QUEUE_DEPTH)) ? '0 : head_ff + QIDX_W'(1);
      cnt_wide     = 32'(count_ff);
      cnt_dec_wide = cnt_wide - 32'd1;
   end

   always_comb begin
      for (int i = 0; i < MAX_SERVERS; i++) busy_in[i] = busy_ff[i];
      head_in     = head_ff;
      count_in    = count_ff;
      next_job_in = next_job_ff;
      last_in     = last_ff;
      acc_in      = acc_ff;
      arrivals_in = arrivals_ff;
      drops_in    = drops_ff;
      done_in     = done_ff;
      r1_in       = r1_ff;
      r2_in       = r2_ff;
      two_in      = two_ff;
      swr_en      = 1'b0;
      swr_idx     = free_idx;
      swr_job     = next_job_ff;
      swr_arr     = now_ff;
      q_we        = 1'b0;
      q_waddr     = tail;
      q_wdata     = {svc_ff, now_ff, next_job_ff};

      if (cmd.exec) begin
         acc_in = acc_new;
         if (now_ff > last_ff) last_in = now_ff;
         two_in = 1'b0;
         r1_in                 = '0;
         r1_in.last            = 1'b1;
         r1_in.busy_time_total = acc_new;
         r1_in.arrivals_seen   = arrivals_ff;
         r1_in.jobs_dropped    = drops_ff;
         r1_in.jobs_done       = done_ff;
         r1_in.queue_length    = cnt_wide[QLEN_W-1:0];
         r2_in                 = r1_in;

         if (act_ff == ACT_ARRIVAL) begin
            next_job_in         = next_job_ff + JOB_W'(1);
            arrivals_in         = sat_inc(arrivals_ff);
            r1_in.arrivals_seen = sat_inc(arrivals_ff);
            r1_in.job_number    = next_job_ff;
            if (found) begin
               busy_in[free_idx] = 1'b1;
               swr_en            = 1'b1;
               r1_in.status      = ST_STARTED;
               r1_in.server_used = free_wide[2:0];
               r1_in.finish_at   = add_sat(now_ff, svc_ff);
            end else if (cnt_wide >= qlim) begin
               drops_in           = sat_inc(drops_ff);
               r1_in.jobs_dropped = sat_inc(drops_ff);
               r1_in.status       = ST_DROPPED;
            end else begin
               q_we               = 1'b1;
               count_in           = count_ff + QCNT_W'(1);
               r1_in.queue_length = QLEN_W'(cnt_wide + 32'd1);
               r1_in.status       = ST_QUEUED;
            end
         end else begin
            r1_in.job_number  = fjob_ff;
            r1_in.server_used = sidx_ff;
            if (!depart_ok) begin
               r1_in.status = ST_BAD_DEPART;
            end else begin
               busy_in[sidx]    = 1'b0;
               done_in          = sat_inc(done_ff);
               r1_in.jobs_done  = sat_inc(done_ff);
               r1_in.status     = ST_COMPLETED;
               r1_in.waited     = sub_floor(sstart_ff[sidx], sarr_ff[sidx]);
               r1_in.in_system  = sub_floor(now_ff, sarr_ff[sidx]);
               r1_in.last       = !start_next;
               if (start_next) begin
                  two_in             = 1'b1;
                  busy_in[sidx]      = 1'b1;
                  swr_en             = 1'b1;
                  swr_idx            = sidx;
                  swr_job            = h_job;
                  swr_arr            = h_arr;
                  head_in            = head_next;
                  count_in           = count_ff - QCNT_W'(1);
                  r2_in              = r1_in;
                  r2_in.status       = ST_Q_STARTED;
                  r2_in.last         = 1'b1;
                  r2_in.job_number   = h_job;
                  r2_in.waited       = '0;
                  r2_in.in_system    = '0;
                  r2_in.finish_at    = add_sat(now_ff, h_svc);
                  r2_in.queue_length = cnt_dec_wide[QLEN_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) busy_ff[i] <= 1'b0;
         head_ff     <= '0;
         count_ff    <= '0;
         next_job_ff <= '0;
         last_ff     <= '0;
         acc_ff      <= '0;
         arrivals_ff <= '0;
         drops_ff    <= '0;
         done_ff     <= '0;
         two_ff      <= 1'b0;
      end else begin
         for (int i = 0; i < MAX_SERVERS; i++) busy_ff[i] <= busy_in[i];
         head_ff     <= head_in;
         count_ff    <= count_in;
         next_job_ff <= next_job_in;
         last_ff     <= last_in;
         acc_ff      <= acc_in;
         arrivals_ff <= arrivals_in;
         drops_ff    <= drops_in;
         done_ff     <= done_in;
         two_ff      <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= action;
         now_ff  <= event_time;
         svc_ff  <= service_length;
         sidx_ff <= server_index;
         fjob_ff <= finishing_job;
      end
      if (swr_en) begin
         sjob_ff[swr_idx]   <= swr_job;
         sarr_ff[swr_idx]   <= swr_arr;
         sstart_ff[swr_idx] <= now_ff;
      end
      r1_ff <= r1_in;
      r2_ff <= r2_in;
   end

   assign stat.two_results = two_ff;
   assign result = cmd.sel_second ? r2_ff : r1_ff;
endmodule

FILE: design/multi_server_job_dispatcher.sv
// ----------------------------------------------------------------------------
// multi_server_job_dispatcher
// Dispatches arriving jobs to servers, queues or drops them, and retires them.
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one time-ordered event per transfer: tuser is the action
//   (arrival or departure), tdata the times, server index and job number.
//   rsp_* returns one result per transfer, two for a departure that also
//   starts a queued job; tlast marks the final result of an event and tuser
//   carries the status code.
//   csr_* is an apb-style port holding servers_in_use (0x0) and queue_limit
//   (0x4); write it only while no event is in flight.
// timing:
//   an event is taken in the idle state, executed in the next, and its first
//   result is registered and presented from the send state; the next event
//   is accepted the cycle after the last result transfers. the sequencer
//   handles one event at a time since each event updates the whole server
//   table and queue.
// reset:
//   servers all idle, queue empty, counters and job numbers zero.
//   while rsp_tready is low the result holds and no new event is taken.
// ----------------------------------------------------------------------------
module multi_server_job_dispatcher #(
   parameter int MAX_SERVERS = 8,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,   // event_time, service_length, server_index, finishing_job
   input  logic         req_tuser,   // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [263:0] rsp_tdata,   // job_number, server_used, finish_at, waited, in_system,
                                     // queue_length, busy_time_total, arrivals_seen,
                                     // jobs_dropped, jobs_done
   output logic [2:0]   rsp_tuser,   // status
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import mjd_pkg::*;

   logic [CFG_SRV_W-1:0] servers_ff;
   logic [CFG_QL_W-1:0]  qlimit_ff;
   cmd_type              cmd;
   stat_type             stat;
   rsp_type              result;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         servers_ff <= CFG_SRV_W'(1);
         qlimit_ff  <= CFG_QL_W'(16);
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr[2])
            REG_SERVERS: servers_ff <= csr_pwdata[CFG_SRV_W-1:0];
            REG_QLIMIT:  qlimit_ff  <= csr_pwdata[CFG_QL_W-1:0];
            default:     servers_ff <= servers_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SERVERS: csr_prdata = 32'(servers_ff);
         REG_QLIMIT:  csr_prdata = 32'(qlimit_ff);
         default:     csr_prdata = '0;
      endcase
   end

   mjd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mjd_datapath #(.MAX_SERVERS(MAX_SERVERS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .servers_in_use (servers_ff),
      .queue_limit    (qlimit_ff),
      .action         (req_tuser),
      .event_time     (req_tdata[31:0]),
      .service_length (req_tdata[63:32]),
      .server_index   (req_tdata[66:64]),
      .finishing_job  (req_tdata[82:67]),
      .result         (result)
   );

   assign rsp_tuser = result.status;
   assign rsp_tlast = result.last;
   assign rsp_tdata = {result.jobs_done, result.jobs_dropped, result.arrivals_seen,
                       result.busy_time_total, result.queue_length, result.in_system,
                       result.waited, result.finish_at, result.server_used,
                       result.job_number};
endmodule

FILE: design/mjd_checker.sv
// ----------------------------------------------------------------------------
// mjd_checker
// Port-level checks for the job dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module mjd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic       rsp_tlast,
   input logic [2:0] rsp_tuser
);
   import mjd_pkg::*;

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // one event at a time: no new event right after one is taken
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second event accepted while busy");

   // events are only taken with no result pending
   a_idle_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid)
      else $error("event accepted with result pending");

   // a non-final result is a completion followed by a queued start
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |->
         rsp_tuser == ST_COMPLETED ##1 (rsp_tvalid && rsp_tuser == ST_Q_STARTED))
      else $error("broken result pair");
endmodule

bind multi_server_job_dispatcher mjd_checker u_mjd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
